/* hdl/fps_pkg.sv */
// ============================================================================
// Fourier partial-sum package
// Shared constants, codes, control types and the sine table builder used by
// the Fourier partial-sum waveform core.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  // Wave selection codes; the fourth code selects no wave.
  localparam logic [1:0] WAVE_SAW      = 2'd0;
  localparam logic [1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
  localparam logic [1:0] WAVE_NONE     = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WAVEFORM  = 2'd0;
  localparam logic [1:0] CFG_NUM_TERMS = 2'd1;

  // Weight numerators in Q30: 2/pi, 4/pi and 8/pi^2.
  localparam longint C_SAW = 64'sd683565276;
  localparam longint C_SQR = 64'sd1367130551;
  localparam longint C_TRI = 64'sd870342340;

  // Quarter turn in Q30.
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // Field widths of the table outputs and of one product.
  localparam int SINE_W   = 16;
  localparam int WEIGHT_W = 32;
  localparam int PROD_W   = WEIGHT_W + SINE_W + 1;

  // Control that travels with one term through the table and MAC stages.
  typedef struct packed {
    logic vld;
    logic neg;
  } term_ctl_t;

  // One entry of the quarter-wave sine table, unsigned Q1.15. The angle is
  // i/Q of a quarter turn, and the sine comes from a nine-term Taylor series
  // evaluated in Q30.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i,
                                                   input int unsigned tbits);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          s;
    longint          v;
    a    = (PI_HALF_Q30 * 64'(i) + ((64'd1 << (tbits - 2)) >> 1)) >> (tbits - 2);
    a2   = (a * a + (64'd1 << 29)) >> 30;
    term = a;
    s    = longint'(a);
    term = ((term * a2) >> 30) / 6;
    s    = s - longint'(term);
    term = ((term * a2) >> 30) / 20;
    s    = s + longint'(term);
    term = ((term * a2) >> 30) / 42;
    s    = s - longint'(term);
    term = ((term * a2) >> 30) / 72;
    s    = s + longint'(term);
    term = ((term * a2) >> 30) / 110;
    s    = s - longint'(term);
    term = ((term * a2) >> 30) / 156;
    s    = s + longint'(term);
    term = ((term * a2) >> 30) / 210;
    s    = s - longint'(term);
    term = ((term * a2) >> 30) / 272;
    s    = s + longint'(term);
    if (s < 0) begin
      s = 0;
    end
    v = (s + 64'sd16384) >>> 15;
    if (v > 64'sd32768) begin
      v = 64'sd32768;
    end
    return SINE_W'(v);
  endfunction

endpackage

`default_nettype wire

/* hdl/fourier_partial_sum_waveform_core.sv */
// ============================================================================
// Fourier partial-sum waveform core
// Returns the N-term Fourier partial sum of a sawtooth, square or triangle
// wave at one sample time, one term per cycle on a shared MAC unit.
// ============================================================================
//
//  Channel | Ports                                   | Handshake
//  --------+-----------------------------------------+------------------------
//  in      | in_sample_time                          | in_valid / in_stall
//  out     | out_wave_value, out_saturated           | out_valid / out_stall
//  cfg     | cfg_index, cfg_data                     | cfg_valid / cfg_ready
//
//  The result register loads after each term has passed through the shared
//  multiply-accumulate unit, its table and product stages have drained and
//  the sum has been rounded and saturated. With waveform code 3 or zero
//  terms the sum is skipped and the sequencer goes straight to its final step.
//  The input is stalled from acceptance until the result is loaded, so a new
//  request is not taken until the last one is through; a result waiting on
//  out_stall holds the next one in its final step.
//  Reset is synchronous and active low; cfg_ready is always high.
//
`timescale 1ns / 1ps
`default_nettype none

module fourier_partial_sum_waveform_core #(
  parameter int MAX_TERMS       = 64,
  parameter int TIME_FRAC_BITS  = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Input requests
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [TIME_FRAC_BITS:0]    in_sample_time,
  // Results
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [15:0]              out_wave_value,
  output logic                            out_saturated,
  // Configuration writes
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [6:0]                 cfg_data
);
  import fps_pkg::*;

  localparam int F      = TIME_FRAC_BITS;
  localparam int KW     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W  = ($clog2(MAX_TERMS + 1) > 7) ? $clog2(MAX_TERMS + 1) : 7;
  localparam int ACC_W  = 48 + $clog2(MAX_TERMS + 1);
  localparam logic [1:0] DRAIN_CYC = 2'd2;
  localparam logic [F-1:0] OFF_SAW = {1'b1, {(F-1){1'b0}}};
  localparam logic [F-1:0] OFF_TRI = {2'b01, {(F-2){1'b0}}};

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FINISH} state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         wave_r, wave_nxt;
  logic [6:0]         nterm_r, nterm_nxt;
  logic [F-1:0]       phase_r, phase_nxt;
  logic [F-1:0]       step_r, step_nxt;
  logic [KW-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [1:0]         drain_r, drain_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_value_r, out_value_nxt;
  logic               out_sat_r, out_sat_nxt;

  logic [F-1:0]       t_in;
  logic [F-1:0]       t_off;
  logic [F-1:0]       tt;
  logic [CNT_W-1:0]   n_eff;
  logic               issue;
  logic               clr;

  term_ctl_t          tbl_ctl;
  logic [SINE_W-1:0]  tbl_sine;
  logic signed [WEIGHT_W-1:0] tbl_weight;
  logic signed [15:0] mac_result;
  logic               mac_sat;

  // Time shifted by the wave's offset, modulo one period.
  always_comb begin
    t_in = in_sample_time[F-1:0];
    case (wave_r)
      WAVE_SAW:      t_off = OFF_SAW;
      WAVE_TRIANGLE: t_off = OFF_TRI;
      default:       t_off = '0;
    endcase
    tt = t_in - t_off;
  end

  // Number of terms actually summed.
  always_comb begin
    if (wave_r == WAVE_NONE) begin
      n_eff = '0;
    end else if (CNT_W'(nterm_r) > CNT_W'(MAX_TERMS)) begin
      n_eff = CNT_W'(MAX_TERMS);
    end else begin
      n_eff = CNT_W'(nterm_r);
    end
  end

  // Sequencer and configuration next-state logic.
  always_comb begin
    state_nxt     = state_r;
    wave_nxt      = wave_r;
    nterm_nxt     = nterm_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;
    issue         = 1'b0;
    clr           = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_WAVEFORM:  wave_nxt  = cfg_data[1:0];
        CFG_NUM_TERMS: nterm_nxt = cfg_data;
        default:       ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          clr       = 1'b1;
          phase_nxt = tt;
          step_nxt  = (wave_r == WAVE_SAW) ? tt : {tt[F-2:0], 1'b0};
          idx_nxt   = '0;
          rem_nxt   = n_eff;
          state_nxt = (n_eff == '0) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        issue     = 1'b1;
        phase_nxt = phase_r + step_r;
        idx_nxt   = idx_r + KW'(1);
        rem_nxt   = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          drain_nxt = DRAIN_CYC;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r - 2'd1;
        if (drain_r == 2'd1) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = mac_result;
          out_sat_nxt   = mac_sat;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, configuration and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wave_r      <= WAVE_SAW;
      nterm_r     <= 7'd1;
      rem_r       <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wave_r      <= wave_nxt;
      nterm_r     <= nterm_nxt;
      rem_r       <= rem_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      out_value_r <= out_value_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  // Sine and weight lookup for each issued term.
  fps_tables #(
    .MAX_TERMS       (MAX_TERMS),
    .TIME_FRAC_BITS  (TIME_FRAC_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .KW              (KW)
  ) u_tables (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .phase    (phase_r),
    .idx      (idx_r),
    .wave     (wave_r),
    .ctl_out  (tbl_ctl),
    .sine_mag (tbl_sine),
    .weight   (tbl_weight)
  );

  // Shared multiply-accumulate unit.
  fps_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (clr),
    .ctl      (tbl_ctl),
    .sine_mag (tbl_sine),
    .weight   (tbl_weight),
    .result   (mac_result),
    .sat      (mac_sat)
  );

  assign in_stall       = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_wave_value = out_value_r;
  assign out_saturated  = out_sat_r;

  // An accepted request always starts the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE)
    else $error("accepted request did not start the sequencer");

  // A new result only appears from the final step.
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_FINISH)
    else $error("result appeared outside the final step");

  // Terms are only issued while some remain.
  a_run_has_terms: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> rem_r != '0)
    else $error("term issued with no terms left");

  // The table stage is empty when the sum is taken.
  a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> !tbl_ctl.vld)
    else $error("sum taken with a term still in flight");

endmodule

`default_nettype wire

/* hdl/fps_tables.sv */
// ============================================================================
// Fourier partial-sum tables
// Turns a harmonic phase into a quarter-wave sine lookup and reads the term
// weight for the selected wave; both reads are registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fps_tables #(
  parameter int MAX_TERMS       = 64,
  parameter int TIME_FRAC_BITS  = 16,
  parameter int SINE_TABLE_BITS = 10,
  parameter int KW              = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             issue,
  input  wire logic [TIME_FRAC_BITS-1:0]        phase,
  input  wire logic [KW-1:0]                    idx,
  input  wire logic [1:0]                       wave,
  output fps_pkg::term_ctl_t                    ctl_out,
  output logic [fps_pkg::SINE_W-1:0]            sine_mag,
  output logic signed [fps_pkg::WEIGHT_W-1:0]   weight
);
  import fps_pkg::*;

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int AW      = SINE_TABLE_BITS - 1;

  logic [SINE_W-1:0]          sine_rom [QUARTER+1];
  logic signed [WEIGHT_W-1:0] saw_rom  [MAX_TERMS];
  logic signed [WEIGHT_W-1:0] sqr_rom  [MAX_TERMS];
  logic signed [WEIGHT_W-1:0] tri_rom  [MAX_TERMS];

  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [SINE_TABLE_BITS-3:0] offs;
  logic [AW-1:0]              addr;
  logic                       neg;

  logic [SINE_W-1:0]          sine_r;
  logic signed [WEIGHT_W-1:0] saw_r;
  logic signed [WEIGHT_W-1:0] sqr_r;
  logic signed [WEIGHT_W-1:0] tri_r;
  term_ctl_t                  ctl_r;

  // Sine table contents, one quarter wave including the end point.
  for (genvar i = 0; i <= QUARTER; i++) begin : g_sine
    localparam logic [SINE_W-1:0] S_VAL = sine_entry(i, SINE_TABLE_BITS);
    assign sine_rom[i] = S_VAL;
  end

  // Weight tables in signed Q30, one entry per term.
  for (genvar k = 1; k <= MAX_TERMS; k++) begin : g_weight
    localparam longint DSAW = k;
    localparam longint DSQR = 2 * k - 1;
    localparam longint DTRI = DSQR * DSQR;
    localparam longint MSAW = (C_SAW + DSAW / 2) / DSAW;
    localparam longint MSQR = (C_SQR + DSQR / 2) / DSQR;
    localparam longint MTRI = (C_TRI + DTRI / 2) / DTRI;
    localparam longint WSAW = (k % 2 == 0) ? -MSAW : MSAW;
    localparam longint WTRI = (k % 2 == 0) ? -MTRI : MTRI;
    assign saw_rom[k-1] = WEIGHT_W'(WSAW);
    assign sqr_rom[k-1] = WEIGHT_W'(MSQR);
    assign tri_rom[k-1] = WEIGHT_W'(WTRI);
  end

  // Table index is the top bits of the phase.
  if (TIME_FRAC_BITS >= SINE_TABLE_BITS) begin : g_idx_shr
    assign tab_idx = phase[TIME_FRAC_BITS-1 -: SINE_TABLE_BITS];
  end else begin : g_idx_shl
    assign tab_idx = {phase, {(SINE_TABLE_BITS - TIME_FRAC_BITS){1'b0}}};
  end

  // Quadrant folding: odd quadrants mirror the address, the upper half negates.
  always_comb begin
    offs = tab_idx[SINE_TABLE_BITS-3:0];
    neg  = tab_idx[SINE_TABLE_BITS-1];
    if (tab_idx[SINE_TABLE_BITS-2]) begin
      addr = AW'(QUARTER) - {1'b0, offs};
    end else begin
      addr = {1'b0, offs};
    end
  end

  // Registered table reads.
  always_ff @(posedge clk) begin
    sine_r <= sine_rom[addr];
    saw_r  <= saw_rom[idx];
    sqr_r  <= sqr_rom[idx];
    tri_r  <= tri_rom[idx];
  end

  // Term control is registered together with the reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.vld <= issue;
      ctl_r.neg <= neg;
    end
  end

  // Weight of the selected wave.
  always_comb begin
    case (wave)
      WAVE_SQUARE:   weight = sqr_r;
      WAVE_TRIANGLE: weight = tri_r;
      default:       weight = saw_r;
    endcase
  end

  assign sine_mag = sine_r;
  assign ctl_out  = ctl_r;

endmodule

`default_nettype wire

/* hdl/fps_mac.sv */
// ============================================================================
// Fourier partial-sum multiply-accumulate unit
// Shared signed multiplier and wide accumulator for the series terms, with
// rounding to Q2.14 and saturation of the final sum.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fps_mac #(
  parameter int ACC_W = 55
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 clr,
  input  wire fps_pkg::term_ctl_t                   ctl,
  input  wire logic [fps_pkg::SINE_W-1:0]           sine_mag,
  input  wire logic signed [fps_pkg::WEIGHT_W-1:0]  weight,
  output logic signed [15:0]                        result,
  output logic                                      sat
);
  import fps_pkg::*;

  localparam int RW = ACC_W - 31;
  localparam logic signed [ACC_W-1:0] RND_HALF = {{(ACC_W-31){1'b0}}, 1'b1, 30'b0};
  localparam logic signed [RW-1:0]    SAT_HI   = RW'(32767);
  localparam logic signed [RW-1:0]    SAT_LO   = -(RW'(32768));

  logic signed [SINE_W:0]    sine_s;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      pvld_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   rsum;
  logic signed [RW-1:0]      rnd;

  // Apply the quadrant sign to the sine magnitude.
  always_comb begin
    if (ctl.neg) begin
      sine_s = -$signed({1'b0, sine_mag});
    end else begin
      sine_s = $signed({1'b0, sine_mag});
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    prod_r <= weight * sine_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= ctl.vld;
    end
  end

  // Accumulate stage; a new request clears the sum.
  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r <= '0;
    end else if (pvld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Round half up from Q45 to Q14, then clip to the 16-bit range.
  always_comb begin
    rsum = acc_r + RND_HALF;
    rnd  = rsum[ACC_W-1:31];
    if (rnd > SAT_HI) begin
      result = 16'sh7fff;
      sat    = 1'b1;
    end else if (rnd < SAT_LO) begin
      result = 16'sh8000;
      sat    = 1'b1;
    end else begin
      result = rnd[15:0];
      sat    = 1'b0;
    end
  end

endmodule

`default_nettype wire
